// ===== hw/rtl/point_window_range_query_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef POINT_WINDOW_RANGE_QUERY_CORE_DEFINES_SVH
`define POINT_WINDOW_RANGE_QUERY_CORE_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define PWRQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pwrq assertion failed");

// Checked at every clock edge, reset included.
`define PWRQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pwrq reset assertion failed");

`endif

// ===== hw/rtl/pwrq_pkg.sv =====
// ----------------------------------------------------------------------------
// pwrq_pkg
// Types and constants of the point window range query core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwrq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COORD_W  = 16;
  localparam int TAG_W    = 16;
  localparam int RAD_W    = 12;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_MATCH    = 3'd0,
    ST_NO_MATCH = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_INSERT,
    K_QUERY
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INS_RD,
    B_INS,
    B_Q_RD,
    B_Q_EV,
    B_Q_END,
    B_EMIT
  } bstate_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [TAG_W-1:0]   point_tag;
    logic [RAD_W-1:0]   radius;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COORD_W-1:0] match_x;
    logic [COORD_W-1:0] match_y;
    logic [TAG_W-1:0]   match_tag;
    logic               last;
  } out_req_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TAG_W-1:0]   tag;
    logic [RAD_W-1:0]   radius;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TAG_W-1:0]   tag;
  } point_t;

endpackage

// ===== hw/rtl/pwrq_front.sv =====
// ----------------------------------------------------------------------------
// pwrq_front
// Accepts requests, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwrq_front import pwrq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_req_t in_data,
  output logic    q_valid,
  output cmd_t    q_data,
  input  logic    q_pop
);

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, keep;
  cmd_t       cmd;

  always_comb begin
    keep = 1'b1;
    cmd.x = in_data.point_x;
    cmd.y = in_data.point_y;
    cmd.tag = in_data.point_tag;
    cmd.radius = in_data.radius;
    cmd.kind = K_CLEAR;
    unique case (in_data.opcode)
      OP_CLEAR:  cmd.kind = K_CLEAR;
      OP_INSERT: cmd.kind = K_INSERT;
      OP_QUERY:  cmd.kind = K_QUERY;
      default:   keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hw/rtl/pwrq_back.sv =====
// ----------------------------------------------------------------------------
// pwrq_back
// Executes queued commands on the sorted point memory and drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwrq_back import pwrq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  cmd_t     q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  point_t     mem [CAPACITY];
  point_t     rd_q;

  bstate_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, k_r, k_nxt, idx_r, idx_nxt;
  cmd_t       cmd_r, cmd_nxt;
  point_t     pend_r, pend_nxt;
  logic       have_r, have_nxt;
  status_t    est_r, est_nxt;
  out_req_t   out_r, out_nxt;
  logic       ov_r, load;

  logic       we, rd_en;
  logic [IDX_W-1:0] wa, ra;
  point_t     wd, newp;
  logic       slot_free, greater, hit;
  logic [COORD_W:0] sx_hi, sy_hi, cx_hi, cy_hi;

  assign slot_free = !ov_r || out_ready;
  assign newp      = '{x: cmd_r.x, y: cmd_r.y, tag: cmd_r.tag};
  assign greater   = (rd_q.x > cmd_r.x) || ((rd_q.x == cmd_r.x) && (rd_q.y > cmd_r.y));
  assign sx_hi     = {1'b0, rd_q.x} + {{(COORD_W+1-RAD_W){1'b0}}, cmd_r.radius};
  assign sy_hi     = {1'b0, rd_q.y} + {{(COORD_W+1-RAD_W){1'b0}}, cmd_r.radius};
  assign cx_hi     = {1'b0, cmd_r.x} + {{(COORD_W+1-RAD_W){1'b0}}, cmd_r.radius};
  assign cy_hi     = {1'b0, cmd_r.y} + {{(COORD_W+1-RAD_W){1'b0}}, cmd_r.radius};
  assign hit = (sx_hi >= {1'b0, cmd_r.x}) && ({1'b0, rd_q.x} <= cx_hi) &&
               (sy_hi >= {1'b0, cmd_r.y}) && ({1'b0, rd_q.y} <= cy_hi);

  assign q_pop = (state_r == B_IDLE) && q_valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          if (q_data.kind == K_QUERY) state_nxt = B_Q_RD;
          else if (q_data.kind == K_INSERT && cnt_r != CNT_W'(CAPACITY)) state_nxt = B_INS_RD;
          else state_nxt = B_EMIT;
        end
      end
      B_INS_RD: state_nxt = (k_r == '0) ? B_EMIT : B_INS;
      B_INS:    state_nxt = greater ? B_INS_RD : B_EMIT;
      B_Q_RD:   state_nxt = (idx_r == cnt_r) ? B_Q_END : B_Q_EV;
      B_Q_EV:   state_nxt = (hit && have_r && !slot_free) ? B_Q_EV : B_Q_RD;
      B_Q_END:  state_nxt = slot_free ? B_IDLE : B_Q_END;
      B_EMIT:   state_nxt = slot_free ? B_IDLE : B_EMIT;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    idx_nxt = idx_r;
    cmd_nxt = cmd_r;
    pend_nxt = pend_r;
    have_nxt = have_r;
    est_nxt = est_r;
    out_nxt = out_r;
    load = 1'b0;
    we = 1'b0;
    wa = '0;
    wd = newp;
    rd_en = 1'b0;
    ra = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          cmd_nxt = q_data;
          k_nxt = cnt_r;
          idx_nxt = '0;
          have_nxt = 1'b0;
          est_nxt = ST_INSERTED;
          if (q_data.kind == K_CLEAR) begin
            cnt_nxt = '0;
            est_nxt = ST_CLEARED;
          end else if (q_data.kind == K_INSERT && cnt_r == CNT_W'(CAPACITY)) begin
            est_nxt = ST_FULL;
          end
        end
      end
      B_INS_RD: begin
        if (k_r == '0) begin
          we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          rd_en = 1'b1;
          ra = IDX_W'(k_r - 1'b1);
        end
      end
      B_INS: begin
        we = 1'b1;
        wa = k_r[IDX_W-1:0];
        if (greater) begin
          wd = rd_q;
          k_nxt = k_r - 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_Q_RD: begin
        if (idx_r != cnt_r) begin
          rd_en = 1'b1;
          ra = idx_r[IDX_W-1:0];
        end
      end
      B_Q_EV: begin
        if (!hit) begin
          idx_nxt = idx_r + 1'b1;
        end else if (!have_r) begin
          pend_nxt = rd_q;
          have_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (slot_free) begin
          load = 1'b1;
          out_nxt = '{status: ST_MATCH, match_x: pend_r.x, match_y: pend_r.y,
                      match_tag: pend_r.tag, last: 1'b0};
          pend_nxt = rd_q;
          idx_nxt = idx_r + 1'b1;
        end
      end
      B_Q_END: begin
        if (slot_free) begin
          load = 1'b1;
          if (have_r) begin
            out_nxt = '{status: ST_MATCH, match_x: pend_r.x, match_y: pend_r.y,
                        match_tag: pend_r.tag, last: 1'b1};
          end else begin
            out_nxt = '{status: ST_NO_MATCH, match_x: '0, match_y: '0,
                        match_tag: '0, last: 1'b1};
          end
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          load = 1'b1;
          out_nxt = '{status: est_r, match_x: '0, match_y: '0, match_tag: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    est_r  <= est_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      have_r  <= have_nxt;
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/point_window_range_query_core.sv =====
// ----------------------------------------------------------------------------
// point_window_range_query_core
// Sorted store of tagged 2D points with clear, insert and window query.
// ----------------------------------------------------------------------------
// Each request clears the store, inserts a point or queries a square window.
// Requests pass a two-entry command queue, so the input keeps accepting while
// the back end works, until the queue is full. An insert reads and moves the
// stored points that sort after the new one, one memory read and one write
// per moved point, then writes the new point. A query scans every stored
// point with one memory read and one compare per point, a match stalling the
// scan while the output register is still full, and emits matches in
// ascending x, then y order; each match is held back until the next match or
// the scan end, since it is marked last only once the scan ends. No clearing
// pass is needed after reset, since only entries below the point count are ever read.
`timescale 1ns / 1ps

module point_window_range_query_core import pwrq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  // Command queue handshake between the front and back ends.
  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  pwrq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // The back end owns the point memory and the output register.
  pwrq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/pwrq_checker.sv =====
// ----------------------------------------------------------------------------
// pwrq_checker
// Port-level checks of the point window range query core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_window_range_query_core_defines.svh"

module pwrq_checker import pwrq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  `PWRQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid)
  `PWRQ_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data))
  `PWRQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `PWRQ_ASSERT(a_zero_fields, out_valid && out_data.status != ST_MATCH |-> out_data.match_x == '0 && out_data.match_y == '0 && out_data.match_tag == '0)
  `PWRQ_ASSERT(a_only_match_open, out_valid && !out_data.last |-> out_data.status == ST_MATCH)

endmodule

bind point_window_range_query_core pwrq_checker u_pwrq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point window range query core.
// ----------------------------------------------------------------------------
// Directed requests run first. A table covers the empty store, the extreme
// coordinates, windows that reach below zero, duplicate points and the
// unused opcode; a fill run then covers a full store. Random traffic follows:
// mostly inserts and queries on a clustered point set, with random clears.
// A local model of the sorted store predicts every result. Each result is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pwrq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_data;

  point_window_range_query_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Model of the sorted point store.
  point_t   store_pts[CAPACITY];
  int       store_cnt;
  out_req_t pending_results[$];
  int       err_count;
  int       result_count;
  int       query_count;
  int       full_count;

  // One row of the directed table. When has_exp is set, the single result
  // of the request is checked against the typed-in exp_status.
  typedef struct {
    in_req_t req;
    bit      has_exp;
    status_t exp_status;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout with %0d results pending", pending_results.size());
    $display("point_window_range_query_core: mismatch");
    $finish;
  end

  function automatic out_req_t make_result(status_t st, point_t p, bit lst);
    out_req_t r;
    r.status    = st;
    r.match_x   = p.x;
    r.match_y   = p.y;
    r.match_tag = p.tag;
    r.last      = lst;
    return r;
  endfunction

  // Appends one expected result at the tail of the pending list.
  task automatic queue_result(input out_req_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Applies one request to the store and queues the results it causes.
  task automatic predict_store(input in_req_t rq);
    point_t zero_pt;
    point_t np;
    int pos;
    int hits;
    int xmin, xmax, ymin, ymax;
    zero_pt = '0;
    case (rq.opcode)
      OP_CLEAR: begin
        store_cnt = 0;
        queue_result(make_result(ST_CLEARED, zero_pt, 1'b1));
      end
      OP_INSERT: begin
        if (store_cnt >= CAPACITY) begin
          full_count++;
          queue_result(make_result(ST_FULL, zero_pt, 1'b1));
        end else begin
          // New point goes after every entry that sorts at or before it.
          pos = 0;
          while (pos < store_cnt && (store_pts[pos].x < rq.point_x ||
                 (store_pts[pos].x == rq.point_x && store_pts[pos].y <= rq.point_y)))
            pos++;
          for (int i = store_cnt; i > pos; i--) store_pts[i] = store_pts[i-1];
          np.x   = rq.point_x;
          np.y   = rq.point_y;
          np.tag = rq.point_tag;
          store_pts[pos] = np;
          store_cnt++;
          queue_result(make_result(ST_INSERTED, zero_pt, 1'b1));
        end
      end
      OP_QUERY: begin
        // Window bounds are signed and may fall below zero.
        xmin = int'(rq.point_x) - int'(rq.radius);
        xmax = int'(rq.point_x) + int'(rq.radius);
        ymin = int'(rq.point_y) - int'(rq.radius);
        ymax = int'(rq.point_y) + int'(rq.radius);
        hits = 0;
        query_count++;
        for (int i = 0; i < store_cnt; i++) begin
          if (int'(store_pts[i].x) >= xmin && int'(store_pts[i].x) <= xmax &&
              int'(store_pts[i].y) >= ymin && int'(store_pts[i].y) <= ymax) begin
            queue_result(make_result(ST_MATCH, store_pts[i], 1'b0));
            hits++;
          end
        end
        if (hits == 0)
          queue_result(make_result(ST_NO_MATCH, zero_pt, 1'b1));
        else
          pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: ;  // The unused opcode changes nothing and gives no result.
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("ERROR result %0d: %s got %0h expected %0h", result_count, what, got, want);
  endtask

  // Result side: random stalls, every accepted result checked.
  initial begin
    int stall;
    out_req_t want;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      out_ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.match_x !== want.match_x)
          report_mismatch("match_x", out_data.match_x, want.match_x);
        if (out_data.match_y !== want.match_y)
          report_mismatch("match_y", out_data.match_y, want.match_y);
        if (out_data.match_tag !== want.match_tag)
          report_mismatch("match_tag", out_data.match_tag, want.match_tag);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
      result_count++;
    end
  end

  // Sends one request after a given gap and returns once it is accepted.
  task automatic send_request(input in_req_t rq, input int gap);
    repeat (gap) @(negedge clk);
    in_data  = rq;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_store(rq);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic in_req_t build_req(logic [1:0] op, int x, int y, int tg, int rad);
    in_req_t r;
    r.opcode    = op;
    r.point_x   = COORD_W'(x);
    r.point_y   = COORD_W'(y);
    r.point_tag = TAG_W'(tg);
    r.radius    = RAD_W'(rad);
    return r;
  endfunction

  task automatic add_row(input in_req_t rq, input bit chk, input status_t st);
    dir_row_t row;
    row.req        = rq;
    row.has_exp    = chk;
    row.exp_status = st;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Random coordinate: mostly near a cluster center so queries hit.
  function automatic int rand_coord(int center);
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: v = $urandom_range(0, 1) ? 0 : 65535;
      default: v = center + $urandom_range(0, 200) - 100;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  initial begin
    logic [1:0] op;
    int cx, cy, rad, pick;
    in_req_t rq;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    err_count = 0;
    result_count = 0;
    query_count = 0;
    full_count = 0;
    store_cnt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: empty query, extremes, negative bounds, duplicates.
    add_row(build_req(OP_QUERY, 0, 0, 16'hFFFF, 4095), 1'b1, ST_NO_MATCH);
    add_row(build_req(OP_INSERT, 0, 0, 16'h0001, 0), 1'b1, ST_INSERTED);
    add_row(build_req(OP_INSERT, 65535, 65535, 16'hFFFF, 0), 1'b1, ST_INSERTED);
    add_row(build_req(OP_INSERT, 0, 65535, 16'h00AA, 0), 1'b1, ST_INSERTED);
    add_row(build_req(OP_INSERT, 65535, 0, 16'h5500, 0), 1'b1, ST_INSERTED);
    add_row(build_req(OP_INSERT, 100, 200, 16'h1111, 0), 1'b0, ST_INSERTED);
    add_row(build_req(OP_INSERT, 100, 200, 16'h2222, 0), 1'b0, ST_INSERTED);
    add_row(build_req(OP_INSERT, 100, 150, 16'h3333, 0), 1'b0, ST_INSERTED);
    add_row(build_req(OP_UNUSED, 100, 200, 16'hDEAD, 5), 1'b0, ST_MATCH);
    add_row(build_req(OP_QUERY, 0, 0, 0, 0), 1'b0, ST_MATCH);
    add_row(build_req(OP_QUERY, 50, 50, 0, 4095), 1'b0, ST_MATCH);
    add_row(build_req(OP_QUERY, 100, 200, 0, 50), 1'b0, ST_MATCH);
    add_row(build_req(OP_QUERY, 65535, 65535, 0, 4095), 1'b0, ST_MATCH);
    add_row(build_req(OP_QUERY, 32768, 32768, 0, 4095), 1'b1, ST_NO_MATCH);
    add_row(build_req(OP_QUERY, 110, 210, 0, 10), 1'b0, ST_MATCH);
    add_row(build_req(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF), 1'b1, ST_CLEARED);
    add_row(build_req(OP_QUERY, 100, 200, 0, 4095), 1'b1, ST_NO_MATCH);

    // Rows with a typed-in status expect that status from the core; the
    // result of such a row is still in the pending list when the send ends.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, draw_gap());
      if (dir_rows[i].has_exp)
        pending_results[pending_results.size()-1].status = dir_rows[i].exp_status;
    end

    // Fill the store to the brim and overflow it.
    send_request(build_req(OP_CLEAR, 0, 0, 0, 0), 0);
    for (int i = 0; i < CAPACITY + 2; i++)
      send_request(build_req(OP_INSERT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), 0), draw_gap());
    send_request(build_req(OP_QUERY, 32768, 32768, 0, 4095), draw_gap());

    // Hold off until the core has drained everything.
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    // Random traffic around a cluster center that jumps now and then.
    cx = $urandom_range(0, 65535);
    cy = $urandom_range(0, 65535);
    for (int n = 0; n < 370; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 4) op = OP_UNUSED;
      else if (pick < 58) op = OP_INSERT;
      else op = OP_QUERY;
      if ($urandom_range(0, 40) == 0) begin
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
      end
      rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 150);
      rq = build_req(op, rand_coord(cx), rand_coord(cy), $urandom_range(0, 65535), rad);
      // Now and then repeat a point already stored to exercise duplicates.
      if (op == OP_INSERT && store_cnt > 0 && $urandom_range(0, 5) == 0) begin
        pick = $urandom_range(0, store_cnt - 1);
        rq.point_x = store_pts[pick].x;
        rq.point_y = store_pts[pick].y;
      end
      send_request(rq, ($urandom_range(0, 4) == 0) ? 0 : draw_gap());
    end

    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d results, %0d window queries, %0d inserts into a full store.",
             result_count, query_count, full_count);
    if (err_count == 0) begin
      $display("point_window_range_query_core: match");
    end else begin
      $display("%0d mismatches", err_count);
      $display("point_window_range_query_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pwrq_pkg.sv
hw/rtl/pwrq_front.sv
hw/rtl/pwrq_back.sv
hw/rtl/point_window_range_query_core.sv
hw/rtl/pwrq_checker.sv
verif/tb.sv
